// File: rtl/spcp_pkg.sv
// ----------------------------------------------------------------------------
// spcp_pkg
// Types and fixed widths shared by the segment pair closest points pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package spcp_pkg;

  localparam int CoordW   = 32;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int DotW     = ProdW + 2;
  localparam int WideW    = 2 * DotW + 1;
  localparam int FracW    = 16;
  localparam int ParamW   = FracW + 1;
  localparam int TnW      = DotW + ParamW + 3;
  localparam int EdgeW    = DotW + 2;
  localparam int PtProdW  = DiffW + ParamW + 1;
  localparam int SepW     = DiffW + 1;
  localparam int SqW      = 2 * SepW;
  localparam int SumW     = SqW + 2;
  localparam int DistW    = 63;
  localparam int LimitW   = 16;
  localparam int PipeDepth = 49;

  localparam logic [ParamW-1:0] ParamOne = ParamW'(1) << FracW;
  localparam logic [DistW-1:0]  DistMax  = {DistW{1'b1}};

  typedef struct packed {
    logic signed [CoordW-1:0] first_start_x;
    logic signed [CoordW-1:0] first_start_y;
    logic signed [CoordW-1:0] first_start_z;
    logic signed [CoordW-1:0] first_end_x;
    logic signed [CoordW-1:0] first_end_y;
    logic signed [CoordW-1:0] first_end_z;
    logic signed [CoordW-1:0] second_start_x;
    logic signed [CoordW-1:0] second_start_y;
    logic signed [CoordW-1:0] second_start_z;
    logic signed [CoordW-1:0] second_end_x;
    logic signed [CoordW-1:0] second_end_y;
    logic signed [CoordW-1:0] second_end_z;
  } seg_pair_t;

  typedef struct packed {
    logic        [ParamW-1:0] param_first;
    logic        [ParamW-1:0] param_second;
    logic        [DistW-1:0]  distance_squared;
    logic signed [CoordW-1:0] near_first_x;
    logic signed [CoordW-1:0] near_first_y;
    logic signed [CoordW-1:0] near_first_z;
    logic signed [CoordW-1:0] near_second_x;
    logic signed [CoordW-1:0] near_second_y;
    logic signed [CoordW-1:0] near_second_z;
  } closest_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] p1;
    logic [2:0][CoordW-1:0] p2;
    logic [2:0][DiffW-1:0]  d1;
    logic [2:0][DiffW-1:0]  d2;
  } geo_t;

endpackage

`default_nettype wire

// File: rtl/spcp_delay.sv
// ----------------------------------------------------------------------------
// spcp_delay
// Payload delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] stage_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        stage_q[k] <= stage_q[k-1];
      end
    end
  end

  assign q_o = stage_q[N-1];

endmodule

`default_nettype wire

// File: rtl/spcp_mul.sv
// ----------------------------------------------------------------------------
// spcp_mul
// Two stage signed multiplier: four half-width partial products, then sum.
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_mul #(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [WA-1:0]  a_i,
  input  logic signed [WB-1:0]  b_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int LA = WA / 2;
  localparam int LB = WB / 2;
  localparam int HA = WA - LA;
  localparam int HB = WB - LB;
  localparam int P  = WA + WB;

  logic signed [LA:0]   a_lo;
  logic signed [HA-1:0] a_hi;
  logic signed [LB:0]   b_lo;
  logic signed [HB-1:0] b_hi;

  logic signed [LA+LB+1:0]  ll_q;
  logic signed [LA+HB:0]    lh_q;
  logic signed [HA+LB:0]    hl_q;
  logic signed [HA+HB-1:0]  hh_q;
  logic signed [P-1:0]      p_q;

  assign a_lo = $signed({1'b0, a_i[LA-1:0]});
  assign a_hi = a_i[WA-1:LA];
  assign b_lo = $signed({1'b0, b_i[LB-1:0]});
  assign b_hi = b_i[WB-1:LB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_lo * b_lo;
      lh_q <= a_lo * b_hi;
      hl_q <= a_hi * b_lo;
      hh_q <= a_hi * b_hi;
      p_q  <= (P'(hh_q) <<< (LA + LB)) + (P'(hl_q) <<< LA)
            + (P'(lh_q) <<< LB) + P'(ll_q);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: rtl/spcp_div.sv
// ----------------------------------------------------------------------------
// spcp_div
// Pipelined clamped divider: q = clamp(num/den, 0, 1) in Q1.16, truncated,
// one restoring step per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_div #(
  parameter int W = 8
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [W-1:0]         num_i,
  input  logic signed [W-1:0]         den_i,
  output logic [spcp_pkg::ParamW-1:0] q_o
);

  localparam int Steps = spcp_pkg::FracW;

  logic [W-1:0]     rem_q  [Steps];
  logic [W-1:0]     den_q  [Steps];
  logic [Steps-1:0] quo_q  [Steps+1];
  logic             zero_q [Steps+1];
  logic             one_q  [Steps+1];

  logic [W:0] sh   [Steps];
  logic [W:0] diff [Steps];
  logic       ge   [Steps];

  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      sh[k]   = {rem_q[k], 1'b0};
      diff[k] = sh[k] - {1'b0, den_q[k]};
      ge[k]   = !diff[k][W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      zero_q[0] <= (num_i <= $signed(W'(0)));
      one_q[0]  <= (num_i >= den_i);
      for (int k = 0; k < Steps - 1; k++) begin
        rem_q[k+1] <= ge[k] ? diff[k][W-1:0] : sh[k][W-1:0];
        den_q[k+1] <= den_q[k];
      end
      for (int k = 0; k < Steps; k++) begin
        quo_q[k+1]  <= {quo_q[k][Steps-2:0], ge[k]};
        zero_q[k+1] <= zero_q[k];
        one_q[k+1]  <= one_q[k];
      end
    end
  end

  always_comb begin
    if (zero_q[Steps]) begin
      q_o = '0;
    end else if (one_q[Steps]) begin
      q_o = spcp_pkg::ParamOne;
    end else begin
      q_o = {1'b0, quo_q[Steps]};
    end
  end

endmodule

`default_nettype wire

// File: rtl/segment_pair_closest_points_top.sv
// ----------------------------------------------------------------------------
// segment_pair_closest_points_top
// Closest points of two 3D segments with their squared distance.
// ----------------------------------------------------------------------------
// One segment pair enters per clock unless the pipeline stalls; it stalls as
// a whole only while the output register holds a result that is not taken.
// The depth is set by two chained 16 step restoring dividers (the general s
// quotient, with its clamped s alternatives in parallel lanes, then the t
// quotient) and the 136 bit products feeding them. The user must write
// degenerate_limit over the cfg channel while idle; the block does not check.
`default_nettype none

module segment_pair_closest_points_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  spcp_pkg::seg_pair_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output spcp_pkg::closest_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spcp_pkg::LimitW-1:0]       cfg_data_i
);

  localparam int CoordW  = spcp_pkg::CoordW;
  localparam int DiffW   = spcp_pkg::DiffW;
  localparam int ProdW   = spcp_pkg::ProdW;
  localparam int DotW    = spcp_pkg::DotW;
  localparam int WideW   = spcp_pkg::WideW;
  localparam int ParamW  = spcp_pkg::ParamW;
  localparam int FracW   = spcp_pkg::FracW;
  localparam int TnW     = spcp_pkg::TnW;
  localparam int EdgeW   = spcp_pkg::EdgeW;
  localparam int PtProdW = spcp_pkg::PtProdW;
  localparam int SepW    = spcp_pkg::SepW;
  localparam int SqW     = spcp_pkg::SqW;
  localparam int SumW    = spcp_pkg::SumW;
  localparam int DistW   = spcp_pkg::DistW;
  localparam int Depth   = spcp_pkg::PipeDepth;
  localparam int GeoW    = $bits(spcp_pkg::geo_t);
  localparam int BsW     = DotW + ParamW + 1;

  logic en;
  logic [Depth-1:0] vld_q;
  logic [spcp_pkg::LimitW-1:0] limit_q;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      limit_q <= '0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[Depth-2:0], in_valid_i};
      end
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // stage 1: differences
  logic signed [CoordW-1:0] p1 [3], q1 [3], p2 [3], q2 [3];
  logic signed [CoordW-1:0] p1_q [3], p2_q [3];
  logic signed [DiffW-1:0]  d1_q [3], d2_q [3], r_q [3];

  always_comb begin
    p1[0] = in_data_i.first_start_x;  p1[1] = in_data_i.first_start_y;
    p1[2] = in_data_i.first_start_z;
    q1[0] = in_data_i.first_end_x;    q1[1] = in_data_i.first_end_y;
    q1[2] = in_data_i.first_end_z;
    p2[0] = in_data_i.second_start_x; p2[1] = in_data_i.second_start_y;
    p2[2] = in_data_i.second_start_z;
    q2[0] = in_data_i.second_end_x;   q2[1] = in_data_i.second_end_y;
    q2[2] = in_data_i.second_end_z;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p1_q[k] <= p1[k];
        p2_q[k] <= p2[k];
        d1_q[k] <= DiffW'(q1[k]) - DiffW'(p1[k]);
        d2_q[k] <= DiffW'(q2[k]) - DiffW'(p2[k]);
        r_q[k]  <= DiffW'(p1[k]) - DiffW'(p2[k]);
      end
    end
  end

  spcp_pkg::geo_t geo1, geo44;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      geo1.p1[k] = p1_q[k];
      geo1.p2[k] = p2_q[k];
      geo1.d1[k] = d1_q[k];
      geo1.d2[k] = d2_q[k];
    end
  end

  spcp_delay #(.W(GeoW), .N(43)) u_geo_dly (
    .clk_i(clk_i), .en_i(en), .d_i(geo1), .q_o(geo44)
  );

  // stages 2-3: dot products
  logic signed [ProdW-1:0] aa_q [3], ee_q [3], ff_q [3], cc_q [3], bb_q [3];
  logic signed [DotW-1:0]  a_q, e_q, f_q, c_q, b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        aa_q[k] <= d1_q[k] * d1_q[k];
        ee_q[k] <= d2_q[k] * d2_q[k];
        ff_q[k] <= d2_q[k] * r_q[k];
        cc_q[k] <= d1_q[k] * r_q[k];
        bb_q[k] <= d1_q[k] * d2_q[k];
      end
      a_q <= DotW'(aa_q[0]) + DotW'(aa_q[1]) + DotW'(aa_q[2]);
      e_q <= DotW'(ee_q[0]) + DotW'(ee_q[1]) + DotW'(ee_q[2]);
      f_q <= DotW'(ff_q[0]) + DotW'(ff_q[1]) + DotW'(ff_q[2]);
      c_q <= DotW'(cc_q[0]) + DotW'(cc_q[1]) + DotW'(cc_q[2]);
      b_q <= DotW'(bb_q[0]) + DotW'(bb_q[1]) + DotW'(bb_q[2]);
    end
  end

  // stage 4: degenerate tests and clamped-s numerators
  logic signed [DotW-1:0]  lim_ext;
  logic signed [DotW-1:0]  a4_q;
  logic signed [EdgeW-1:0] neg_c_q, b_minus_c_q;
  logic [1:0]              deg4_q;

  assign lim_ext = DotW'({limit_q, {FracW{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg4_q      <= {a_q <= lim_ext, e_q <= lim_ext};
      a4_q        <= a_q;
      neg_c_q     <= -EdgeW'(c_q);
      b_minus_c_q <= EdgeW'(b_q) - EdgeW'(c_q);
    end
  end

  logic [ParamW-1:0] s_neg21, s_pos21, s_neg43, s_pos43;

  spcp_div #(.W(EdgeW)) u_div_neg (
    .clk_i(clk_i), .en_i(en), .num_i(neg_c_q), .den_i(EdgeW'(a4_q)), .q_o(s_neg21)
  );
  spcp_div #(.W(EdgeW)) u_div_pos (
    .clk_i(clk_i), .en_i(en), .num_i(b_minus_c_q), .den_i(EdgeW'(a4_q)), .q_o(s_pos21)
  );
  spcp_delay #(.W(2 * ParamW), .N(22)) u_spos_dly (
    .clk_i(clk_i), .en_i(en), .d_i({s_neg21, s_pos21}), .q_o({s_neg43, s_pos43})
  );

  // stages 4-6: denominator and general s numerator
  logic signed [2*DotW-1:0] ae5, bb5, bf5, ce5;
  logic signed [WideW-1:0]  denom_q, num0_q;

  spcp_mul #(.WA(DotW), .WB(DotW)) u_mul_ae (
    .clk_i(clk_i), .en_i(en), .a_i(a_q), .b_i(e_q), .p_o(ae5)
  );
  spcp_mul #(.WA(DotW), .WB(DotW)) u_mul_bb (
    .clk_i(clk_i), .en_i(en), .a_i(b_q), .b_i(b_q), .p_o(bb5)
  );
  spcp_mul #(.WA(DotW), .WB(DotW)) u_mul_bf (
    .clk_i(clk_i), .en_i(en), .a_i(b_q), .b_i(f_q), .p_o(bf5)
  );
  spcp_mul #(.WA(DotW), .WB(DotW)) u_mul_ce (
    .clk_i(clk_i), .en_i(en), .a_i(c_q), .b_i(e_q), .p_o(ce5)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      denom_q <= WideW'(ae5) - WideW'(bb5);
      num0_q  <= WideW'(bf5) - WideW'(ce5);
    end
  end

  logic              dz23;
  logic [ParamW-1:0] div0_23, s0_23, s0_43;

  spcp_div #(.W(WideW)) u_div_s (
    .clk_i(clk_i), .en_i(en), .num_i(num0_q), .den_i(denom_q), .q_o(div0_23)
  );
  spcp_delay #(.W(1), .N(17)) u_dz_dly (
    .clk_i(clk_i), .en_i(en), .d_i(denom_q == '0), .q_o(dz23)
  );

  assign s0_23 = dz23 ? '0 : div0_23;

  spcp_delay #(.W(ParamW), .N(20)) u_s0_dly (
    .clk_i(clk_i), .en_i(en), .d_i(s0_23), .q_o(s0_43)
  );

  // stages 23-26: t numerator b*s + f, denominator e
  logic signed [DotW-1:0] b23, f25, e25;
  logic [1:0]             deg25, deg43;
  logic signed [BsW-1:0]  bs25;

  spcp_delay #(.W(DotW), .N(20)) u_b_dly (
    .clk_i(clk_i), .en_i(en), .d_i(b_q), .q_o(b23)
  );
  spcp_delay #(.W(2 * DotW), .N(22)) u_fe_dly (
    .clk_i(clk_i), .en_i(en), .d_i({f_q, e_q}), .q_o({f25, e25})
  );
  spcp_delay #(.W(2), .N(21)) u_deg_dly (
    .clk_i(clk_i), .en_i(en), .d_i(deg4_q), .q_o(deg25)
  );
  spcp_delay #(.W(2), .N(18)) u_deg2_dly (
    .clk_i(clk_i), .en_i(en), .d_i(deg25), .q_o(deg43)
  );
  spcp_mul #(.WA(DotW), .WB(ParamW + 1)) u_mul_bs (
    .clk_i(clk_i), .en_i(en), .a_i(b23), .b_i($signed({1'b0, s0_23})), .p_o(bs25)
  );

  logic signed [TnW-1:0] tn_d, td_d, tnum_q, tden_q;
  logic                  tneg_q, tgt_q, tneg43, tgt43;
  logic [ParamW-1:0]     t_div43;

  assign tn_d = TnW'(bs25) + (TnW'(f25) <<< FracW);
  assign td_d = TnW'(e25) <<< FracW;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tnum_q <= deg25[1] ? TnW'(f25) : tn_d;
      tden_q <= deg25[1] ? TnW'(e25) : td_d;
      tneg_q <= tn_d < $signed(TnW'(0));
      tgt_q  <= tn_d > td_d;
    end
  end

  spcp_div #(.W(TnW)) u_div_t (
    .clk_i(clk_i), .en_i(en), .num_i(tnum_q), .den_i(tden_q), .q_o(t_div43)
  );
  spcp_delay #(.W(2), .N(17)) u_tflag_dly (
    .clk_i(clk_i), .en_i(en), .d_i({tneg_q, tgt_q}), .q_o({tneg43, tgt43})
  );

  // stage 44: pick s and t
  logic [ParamW-1:0] s_d, t_d, s_q, t_q;

  always_comb begin
    if (deg43[1] && deg43[0]) begin
      s_d = '0;
      t_d = '0;
    end else if (deg43[1]) begin
      s_d = '0;
      t_d = t_div43;
    end else if (deg43[0] || tneg43) begin
      s_d = s_neg43;
      t_d = '0;
    end else if (tgt43) begin
      s_d = s_pos43;
      t_d = spcp_pkg::ParamOne;
    end else begin
      s_d = s0_43;
      t_d = t_div43;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q <= s_d;
      t_q <= t_d;
    end
  end

  // stages 45-48: closest points, separation, squares
  logic signed [PtProdW-1:0] m1_q [3], m2_q [3], h1 [3], h2 [3];
  logic signed [CoordW-1:0]  p1_45q [3], p2_45q [3];
  logic [2:0][DiffW-1:0]     c1_q, c2_q, c1_48, c2_48;
  logic signed [SepW-1:0]    dd_q [3];
  logic [SqW-1:0]            sq_q [3];
  logic [ParamW-1:0]         s48, t48;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h1[k] = (m1_q[k] + PtProdW'(32768)) >>> FracW;
      h2[k] = (m2_q[k] + PtProdW'(32768)) >>> FracW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m1_q[k]   <= $signed(geo44.d1[k]) * $signed({1'b0, s_q});
        m2_q[k]   <= $signed(geo44.d2[k]) * $signed({1'b0, t_q});
        p1_45q[k] <= $signed(geo44.p1[k]);
        p2_45q[k] <= $signed(geo44.p2[k]);
        c1_q[k]   <= DiffW'(PtProdW'(p1_45q[k]) + h1[k]);
        c2_q[k]   <= DiffW'(PtProdW'(p2_45q[k]) + h2[k]);
        dd_q[k]   <= SepW'($signed(c1_q[k])) - SepW'($signed(c2_q[k]));
        sq_q[k]   <= SqW'(dd_q[k] * dd_q[k]);
      end
    end
  end

  spcp_delay #(.W(2 * ParamW), .N(4)) u_st_dly (
    .clk_i(clk_i), .en_i(en), .d_i({s_q, t_q}), .q_o({s48, t48})
  );
  spcp_delay #(.W(6 * DiffW), .N(2)) u_pt_dly (
    .clk_i(clk_i), .en_i(en), .d_i({c1_q, c2_q}), .q_o({c1_48, c2_48})
  );

  // stage 49: output register
  logic [SumW-1:0]    dist_sum;
  spcp_pkg::closest_t out_q;

  assign dist_sum = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.param_first      <= s48;
      out_q.param_second     <= t48;
      out_q.distance_squared <= (dist_sum > SumW'(spcp_pkg::DistMax))
                                ? spcp_pkg::DistMax : dist_sum[DistW-1:0];
      out_q.near_first_x     <= c1_48[0][CoordW-1:0];
      out_q.near_first_y     <= c1_48[1][CoordW-1:0];
      out_q.near_first_z     <= c1_48[2][CoordW-1:0];
      out_q.near_second_x    <= c2_48[0][CoordW-1:0];
      out_q.near_second_y    <= c2_48[1][CoordW-1:0];
      out_q.near_second_z    <= c2_48[2][CoordW-1:0];
    end
  end

  assign out_data_o = out_q;

  a_param_first_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.param_first <= spcp_pkg::ParamOne)
    else $error("param_first above one");

  a_param_second_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.param_second <= spcp_pkg::ParamOne)
    else $error("param_second above one");

  a_same_point_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.near_first_x == out_data_o.near_second_x
     && out_data_o.near_first_y == out_data_o.near_second_y
     && out_data_o.near_first_z == out_data_o.near_second_z)
    |-> out_data_o.distance_squared == '0)
    else $error("coincident points with nonzero distance");

endmodule

`default_nettype wire

// File: sim/tb_segment_pair_closest_points_top.sv
// ----------------------------------------------------------------------------
// tb_segment_pair_closest_points_top
// Drives random and corner segment pairs into the closest points pipeline
// under random idling on both sides, with several degenerate limits, and
// checks every result field by field against an exact integer model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_pair_closest_points_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          Latency = spcp_pkg::PipeDepth + 4;
  localparam longint      CycleLimit = 400000;
  localparam int          QOne = 65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  spcp_pkg::seg_pair_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  spcp_pkg::closest_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [spcp_pkg::LimitW-1:0] cfg_data_i = '0;

  spcp_pkg::closest_t expected_q[$];
  logic [spcp_pkg::LimitW-1:0] limit_val = '0;
  int errors = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;

  segment_pair_closest_points_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // clamp(num/den) to [0,1] in Q1.16, truncated; den > 0
  function automatic logic [16:0] clamp_quot(logic signed [255:0] num,
                                             logic signed [255:0] den);
    if (num <= 0) return 17'd0;
    if (num >= den) return 17'(QOne);
    return 17'((num * QOne) / den);
  endfunction

  function automatic logic signed [63:0] round_q16(logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + 32768;
    return y >>> 16;
  endfunction

  function automatic spcp_pkg::closest_t closest_points(spcp_pkg::seg_pair_t p);
    logic signed [63:0] p1[3], q1[3], p2[3], q2[3], d1[3], d2[3], r[3];
    logic signed [63:0] c1[3], c2[3], dd;
    logic signed [255:0] a, e, f, c, b, lim, denom, tn, td, sq_sum;
    logic [16:0] s, t;
    spcp_pkg::closest_t o;
    p1 = '{p.first_start_x, p.first_start_y, p.first_start_z};
    q1 = '{p.first_end_x, p.first_end_y, p.first_end_z};
    p2 = '{p.second_start_x, p.second_start_y, p.second_start_z};
    q2 = '{p.second_end_x, p.second_end_y, p.second_end_z};
    a = 0; e = 0; f = 0; c = 0; b = 0; sq_sum = 0; s = 0; t = 0;
    for (int k = 0; k < 3; k++) begin
      d1[k] = q1[k] - p1[k];
      d2[k] = q2[k] - p2[k];
      r[k] = p1[k] - p2[k];
      a += 256'(d1[k]) * 256'(d1[k]);
      e += 256'(d2[k]) * 256'(d2[k]);
      f += 256'(d2[k]) * 256'(r[k]);
      c += 256'(d1[k]) * 256'(r[k]);
      b += 256'(d1[k]) * 256'(d2[k]);
    end
    lim = 256'(limit_val) << 16;
    if (a <= lim && e <= lim) begin
      s = 0; t = 0;
    end else if (a <= lim) begin
      t = clamp_quot(f, e);
    end else if (e <= lim) begin
      s = clamp_quot(-c, a);
    end else begin
      denom = a * e - b * b;
      s = (denom == 0) ? 17'd0 : clamp_quot(b * f - c * e, denom);
      tn = b * $signed({239'd0, s}) + f * QOne;
      td = e * QOne;
      if (tn < 0) begin
        t = 0;
        s = clamp_quot(-c, a);
      end else if (tn > td) begin
        t = 17'(QOne);
        s = clamp_quot(b - c, a);
      end else begin
        t = clamp_quot(tn, td);
      end
    end
    for (int k = 0; k < 3; k++) begin
      c1[k] = p1[k] + round_q16(d1[k] * $signed({47'd0, s}));
      c2[k] = p2[k] + round_q16(d2[k] * $signed({47'd0, t}));
      dd = c1[k] - c2[k];
      sq_sum += 256'(dd) * 256'(dd);
    end
    o.param_first = s;
    o.param_second = t;
    o.distance_squared = (sq_sum > 256'(spcp_pkg::DistMax)) ? spcp_pkg::DistMax
                                                             : sq_sum[62:0];
    o.near_first_x = c1[0][31:0]; o.near_first_y = c1[1][31:0];
    o.near_first_z = c1[2][31:0];
    o.near_second_x = c2[0][31:0]; o.near_second_y = c2[1][31:0];
    o.near_second_z = c2[2][31:0];
    return o;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 32);
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", field, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    spcp_pkg::closest_t w;
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.distance_squared, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_data_o.param_first !== w.param_first)
          report_mismatch("param_first", out_data_o.param_first, w.param_first);
        if (out_data_o.param_second !== w.param_second)
          report_mismatch("param_second", out_data_o.param_second, w.param_second);
        if (out_data_o.distance_squared !== w.distance_squared)
          report_mismatch("distance_squared", out_data_o.distance_squared,
                          w.distance_squared);
        if (out_data_o.near_first_x !== w.near_first_x)
          report_mismatch("near_first_x", out_data_o.near_first_x, w.near_first_x);
        if (out_data_o.near_first_y !== w.near_first_y)
          report_mismatch("near_first_y", out_data_o.near_first_y, w.near_first_y);
        if (out_data_o.near_first_z !== w.near_first_z)
          report_mismatch("near_first_z", out_data_o.near_first_z, w.near_first_z);
        if (out_data_o.near_second_x !== w.near_second_x)
          report_mismatch("near_second_x", out_data_o.near_second_x, w.near_second_x);
        if (out_data_o.near_second_y !== w.near_second_y)
          report_mismatch("near_second_y", out_data_o.near_second_y, w.near_second_y);
        if (out_data_o.near_second_z !== w.near_second_z)
          report_mismatch("near_second_z", out_data_o.near_second_z, w.near_second_z);
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= !idle_now();
  end

  task automatic send_pair(spcp_pkg::seg_pair_t p);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(closest_points(p));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [spcp_pkg::LimitW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    limit_val = v;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 << 16)) - (1 << 16));
      2: return 32'($signed($urandom_range(400)) - 200);
      default: return 32'($signed($urandom_range(32'h0100_0000)) - 32'h0080_0000);
    endcase
  endfunction

  function automatic spcp_pkg::seg_pair_t rand_pair();
    spcp_pkg::seg_pair_t p;
    int mode;
    logic [31:0] v[12];
    mode = $urandom_range(3);
    foreach (v[i]) v[i] = rand_coord(mode);
    case ($urandom_range(7))
      0: v[3:5] = v[0:2];                         // first collapsed
      1: v[9:11] = v[6:8];                        // second collapsed
      2: begin                                    // parallel, offset copy
        for (int k = 0; k < 3; k++) v[9 + k] = v[6 + k] + (v[3 + k] - v[k]);
      end
      3: for (int k = 0; k < 3; k++) v[3 + k] = v[k] + 32'($urandom_range(3)); // tiny
      default: ;
    endcase
    p = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
    return p;
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn, one;
    mx = 32'h7fff_ffff; mn = 32'h8000_0000; one = 32'h0001_0000;
    send_pair('0);
    send_pair({mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mn});
    send_pair({mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx});
    send_pair({mn, mn, mn, mn, mn, mn, mx, mx, mx, mx, mx, mx});
    send_pair({32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0,
               32'd0, one, 32'd0, one, one, 32'd0});
    send_pair({32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0,
               32'd0, 32'd0, one, 32'd0, one, one});
    send_pair({32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0,
               -one, one, 32'd0, -one, one, one});
    send_pair({32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0,
               32'h0003_0000, one, 32'd0, 32'h0003_0000, one, one});
    send_pair({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
               one, one, one, 32'h0002_0000, one, one});
    send_pair({one, one, one, 32'h0002_0000, one, one,
               32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_pair({32'd5, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
               32'd3, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3});
    send_pair({32'd0, 32'd0, 32'd0, one, one, one,
               32'd0, 32'd0, 32'd0, one, one, one});
    send_pair({32'd0, 32'd0, 32'd0, 32'd3, 32'd0, 32'd0,
               32'd1, 32'd1, 32'd0, 32'd2, 32'd1, 32'd0});
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 2) && (i < count / 2 + 80);
      send_pair(rand_pair());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_limits();
    logic [spcp_pkg::LimitW-1:0] lims[4];
    lims = '{16'hffff, 16'd1, 16'h0100, 16'd0};
    foreach (lims[i]) begin
      drain();
      write_limit(lims[i]);
      test_directed();
      test_random(150);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    test_limits();
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/spcp_pkg.sv
rtl/spcp_delay.sv
rtl/spcp_mul.sv
rtl/spcp_div.sv
rtl/segment_pair_closest_points_top.sv
sim/tb_segment_pair_closest_points_top.sv
